/* rtl/olir_pkg.sv */
// Package for the ordered list with insert and remove.
// Holds the sizes, the operation and status codes and the control structs.
// Depends on nothing; every other file of the block uses it.
package olir_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  typedef struct packed {
    logic edit;
    logic dump;
  } cmd_t;

  typedef struct packed {
    logic             dump_last;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

/* rtl/olir_if.sv */
// Valid/ready channel interfaces for the operation and result beats.
// Depends on olir_pkg for the field widths.
interface olir_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic [olir_pkg::POS_W-1:0]        position;
  logic signed [olir_pkg::VAL_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink (input valid, op, position, value, output ready);
endinterface

interface olir_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [olir_pkg::VAL_W-1:0] element;
  logic                              element_valid;
  logic [olir_pkg::CNT_W-1:0]        count;
  logic                              last;

  modport source (output valid, status, element, element_valid, count, last, input ready);
  modport sink (input valid, status, element, element_valid, count, last, output ready);
endinterface

/* rtl/olir_ctrl.sv */
// Controller of the ordered list: sequences edits and dump beats.
// Depends on olir_pkg; drives the datapath through cmd_t and reads stat_t.
module olir_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  olir_pkg::op_e   in_op_i,
  input  logic            out_ready_i,
  input  olir_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output olir_pkg::cmd_t  cmd_o
);

  olir_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olir_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      olir_pkg::S_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          out_valid_d = 1'b1;
          if (in_op_i == olir_pkg::OP_DUMP) begin
            cmd_o.dump = 1'b1;
            if (!stat_i.dump_last) begin
              state_d = olir_pkg::S_DUMP;
            end
          end else begin
            cmd_o.edit = 1'b1;
          end
        end
      end
      olir_pkg::S_DUMP: begin
        if (slot_free) begin
          cmd_o.dump  = 1'b1;
          out_valid_d = 1'b1;
          if (stat_i.dump_last) begin
            state_d = olir_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = olir_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_no_accept_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == olir_pkg::S_DUMP |-> !in_ready_o)
    else $error("operation accepted during a dump");

  a_long_dump_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_op_i == olir_pkg::OP_DUMP && stat_i.count > 7'd1)
    |=> state_q == olir_pkg::S_DUMP)
    else $error("dump of several entries did not enter the dump state");

  a_cmd_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.edit || cmd_o.dump) |=> out_valid_q)
    else $error("datapath load without a result beat");

endmodule

/* rtl/olir_dpath.sv */
// Datapath of the ordered list: a chain of entry cells, the count, the
// dump index and the result register. Depends on olir_pkg.
module olir_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  olir_pkg::cmd_t                    cmd_i,
  input  olir_pkg::op_e                     op_i,
  input  logic [olir_pkg::POS_W-1:0]        position_i,
  input  logic signed [olir_pkg::VAL_W-1:0] value_i,
  output olir_pkg::stat_t                   stat_o,
  output logic [1:0]                        status_o,
  output logic signed [olir_pkg::VAL_W-1:0] element_o,
  output logic                              element_valid_o,
  output logic [olir_pkg::CNT_W-1:0]        count_o,
  output logic                              last_o
);

  localparam int unsigned DEPTH = olir_pkg::DEPTH;
  localparam int unsigned CNT_W = olir_pkg::CNT_W;
  localparam int unsigned VAL_W = olir_pkg::VAL_W;

  logic signed [VAL_W-1:0] cells_q [DEPTH];
  logic signed [VAL_W-1:0] cell_d  [DEPTH];
  logic signed [VAL_W-1:0] prev_w  [DEPTH];
  logic signed [VAL_W-1:0] next_w  [DEPTH];

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   epos;
  logic               bad, full, dump_last;
  logic               do_ins, do_rem, do_rot;
  olir_pkg::status_e  edit_st;

  logic [1:0]              status_q;
  logic signed [VAL_W-1:0] element_q;
  logic                    element_valid_q;
  logic [CNT_W-1:0]        rcount_q;
  logic                    last_q;

  assign epos = (op_i == olir_pkg::OP_APPEND) ? count_q : position_i;
  assign full = (count_q == CNT_W'(DEPTH));
  assign bad  = ((op_i == olir_pkg::OP_INSERT) && (position_i > count_q)) ||
                ((op_i == olir_pkg::OP_REMOVE) && (position_i >= count_q));

  always_comb begin
    if (bad) begin
      edit_st = olir_pkg::ST_BADPOS;
    end else if ((op_i != olir_pkg::OP_REMOVE) && full) begin
      edit_st = olir_pkg::ST_FULL;
    end else begin
      edit_st = olir_pkg::ST_OK;
    end
  end

  assign do_ins = cmd_i.edit && (edit_st == olir_pkg::ST_OK) &&
                  ((op_i == olir_pkg::OP_APPEND) || (op_i == olir_pkg::OP_INSERT));
  assign do_rem = cmd_i.edit && (edit_st == olir_pkg::ST_OK) &&
                  (op_i == olir_pkg::OP_REMOVE);
  assign do_rot = cmd_i.dump && (count_q != '0);

  assign dump_last = ((idx_q + CNT_W'(1)) >= count_q);

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.dump) begin
      idx_d = dump_last ? '0 : idx_q + CNT_W'(1);
    end
  end

  // Each cell takes its neighbour below on an insert, its neighbour above on
  // a remove, and the dump rotates the list down by one with the head wrapping
  // to the tail, so that the whole list is back in place after the dump.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);

    if (i > 0) begin : g_prev
      assign prev_w[i] = cells_q[i-1];
    end else begin : g_prev0
      assign prev_w[i] = cells_q[i];
    end

    if (i < DEPTH - 1) begin : g_next
      assign next_w[i] = cells_q[i+1];
    end else begin : g_next_top
      assign next_w[i] = cells_q[i];
    end

    always_comb begin
      cell_d[i] = cells_q[i];
      if (do_ins) begin
        if (IDX == epos) begin
          cell_d[i] = value_i;
        end else if ((IDX > epos) && (IDX <= count_q)) begin
          cell_d[i] = prev_w[i];
        end
      end else if (do_rem) begin
        if ((IDX >= position_i) && (IDX1 < count_q)) begin
          cell_d[i] = next_w[i];
        end
      end else if (do_rot) begin
        if (IDX1 < count_q) begin
          cell_d[i] = next_w[i];
        end else if (IDX1 == count_q) begin
          cell_d[i] = cells_q[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DEPTH; j++) begin
      cells_q[j] <= cell_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edit) begin
      status_q        <= edit_st;
      element_q       <= '0;
      element_valid_q <= 1'b0;
      rcount_q        <= count_d;
      last_q          <= 1'b1;
    end else if (cmd_i.dump) begin
      status_q        <= olir_pkg::ST_OK;
      element_q       <= (count_q != '0) ? cells_q[0] : '0;
      element_valid_q <= (count_q != '0);
      rcount_q        <= count_q;
      last_q          <= dump_last;
    end
  end

  assign stat_o.dump_last = dump_last;
  assign stat_o.count     = count_q;
  assign status_o         = status_q;
  assign element_o        = element_q;
  assign element_valid_o  = element_valid_q;
  assign count_o          = rcount_q;
  assign last_o           = last_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_dump_index_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.dump && dump_last) |=> idx_q == '0)
    else $error("dump index not cleared after the final beat");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rem |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not lower the count by one");

endmodule

/* rtl/ordered_list_insert_remove.sv */
// Top level of the ordered list with insert and remove.
// Joins olir_ctrl and olir_dpath to the channel interfaces of olir_if.
//
//   channel  dir  beat fields
//   in_i     in   op, position, value
//   out_o    out  status, element, element_valid, count, last
//
// An edit shifts the whole cell chain at once; the result beat is shown in the
// next cycle. A dump gives one beat per entry (one for an empty list), one entry
// each cycle unless the output stalls, as the cell chain rotates by one entry.
// Reset clears the count and the control state; the entries need no clearing.
// The result register takes a new operation at the edge where the previous beat
// is taken, so operations can follow with no gap; a stalled output holds the
// chain and blocks new operations until the beat is taken.
module ordered_list_insert_remove (
  input  logic       clk_i,
  input  logic       rst_ni,
  olir_in_if.sink    in_i,
  olir_out_if.source out_o
);

  olir_pkg::cmd_t  cmd;
  olir_pkg::stat_t stat;
  logic            in_ready;
  logic            out_valid;

  olir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (olir_pkg::op_e'(in_i.op)),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  olir_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (olir_pkg::op_e'(in_i.op)),
    .position_i      (in_i.position),
    .value_i         (in_i.value),
    .stat_o          (stat),
    .status_o        (out_o.status),
    .element_o       (out_o.element),
    .element_valid_o (out_o.element_valid),
    .count_o         (out_o.count),
    .last_o          (out_o.last)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
